>>> rtl/core/assert_macros.svh
// Assertion macros shared by the checker files of this block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STSS_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stss port check failed");

// The consequent must hold in the cycle after the antecedent.
`define STSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stss port check failed");

`endif

>>> rtl/core/stss_pkg.sv
package stss_pkg;

    localparam int ADC_W           = 10;
    localparam int CFG_W           = 16;
    localparam int MCAND_W         = 20;
    localparam int PROD_W          = 30;
    localparam int AVG_W           = 14;
    localparam int DIGIT_W         = 4;
    localparam int NUM_DIGITS      = 4;
    localparam int BCD_W           = DIGIT_W * NUM_DIGITS;
    localparam int SEG_W           = 8;
    localparam int EN_W            = 4;
    localparam int DIVISOR_W       = 10;
    localparam int IN_TDATA_W      = 16;
    localparam int OUT_TDATA_W     = 32;
    localparam int APB_DATA_W      = 32;
    localparam int APB_ADDR_W      = 3;
    localparam int SAMPLE_MAX      = 9999;
    localparam int AVG_DEPTH_DEFAULT = 8;

    localparam logic [PROD_W-1:0]    ROUND_BIAS    = 30'd511;
    localparam logic [PROD_W-1:0]    SAT_LIMIT     = 30'd10230000;
    localparam logic [DIVISOR_W-1:0] SCALE_DIVISOR = 10'd1023;
    localparam logic [AVG_W-1:0]     SAT_VALUE     = 14'd9999;
    localparam logic [CFG_W-1:0]     VREF_RESET    = 16'd5000;
    localparam logic [CFG_W-1:0]     FRAMES_RESET  = 16'd250;
    localparam logic [SEG_W-1:0]     DP_MASK       = 8'h80;

    typedef enum logic
    {
        KIND_PRIME = 1'b0,
        KIND_SCAN  = 1'b1
    } kind_t;

    typedef enum logic
    {
        REG_VREF_MV       = 1'b0,
        REG_SAMPLE_FRAMES = 1'b1
    } reg_index_t;

    typedef enum logic [1:0]
    {
        POS_UNITS     = 2'd0,
        POS_TENS      = 2'd1,
        POS_HUNDREDS  = 2'd2,
        POS_THOUSANDS = 2'd3
    } scan_pos_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_RING_RD,
        ST_RING_UPD,
        ST_AVG_GO,
        ST_AVG_WAIT,
        ST_BCD_GO,
        ST_BCD_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed
    {
        logic busy;
        logic done;
    } unit_status_t;

    function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] pattern;
        case (digit)
            4'd0:    pattern = 8'h3F;
            4'd1:    pattern = 8'h06;
            4'd2:    pattern = 8'h5B;
            4'd3:    pattern = 8'h4F;
            4'd4:    pattern = 8'h66;
            4'd5:    pattern = 8'h6D;
            4'd6:    pattern = 8'h7D;
            4'd7:    pattern = 8'h07;
            4'd8:    pattern = 8'h7F;
            4'd9:    pattern = 8'h6F;
            default: pattern = 8'h00;
        endcase
        return pattern;
    endfunction

endpackage

>>> rtl/core/stss_sermul.sv
// Shift-and-add multiplier, one multiplier bit per cycle.
module stss_sermul
    import stss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [ADC_W-1:0]     multiplier,
    input  logic [MCAND_W-1:0]   multiplicand,
    output logic [PROD_W-1:0]    product,
    output unit_status_t         status
);

    localparam int CNT_W = $clog2(ADC_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ADC_W - 1);

    logic [PROD_W-1:0] acc_reg;
    logic [PROD_W-1:0] mcand_reg;
    logic [ADC_W-1:0]  mplier_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= PROD_W'(multiplicand);
            mplier_reg <= multiplier;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign product     = acc_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

>>> rtl/core/stss_serdiv.sv
// Restoring divider producing one quotient bit per cycle. The caller
// guarantees that the dividend bits above the quotient width are below
// the divisor, so the quotient fits in AVG_W bits.
module stss_serdiv
    import stss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [PROD_W-1:0]    dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output logic [AVG_W-1:0]     quotient,
    output unit_status_t         status
);

    localparam int CNT_W = $clog2(AVG_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(AVG_W - 1);

    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] divisor_reg;
    logic [AVG_W-1:0]     work_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [PROD_W-1:0]    high_part;
    logic [DIVISOR_W:0]   trial;
    logic                 fits;

    assign high_part = dividend >> AVG_W;
    assign trial     = {rem_reg, work_reg[AVG_W-1]};
    assign fits      = (trial >= {1'b0, divisor_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= high_part[DIVISOR_W-1:0];
            work_reg    <= dividend[AVG_W-1:0];
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= DIVISOR_W'(trial - {1'b0, divisor_reg});
            end
            else
            begin
                rem_reg <= trial[DIVISOR_W-1:0];
            end
            work_reg <= {work_reg[AVG_W-2:0], fits};
        end
    end

    assign quotient    = work_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

>>> rtl/core/stss_bcd.sv
// Binary to decimal conversion by shift-and-add-3, one input bit per cycle.
module stss_bcd
    import stss_pkg::*;
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [AVG_W-1:0]                      value,
    output logic [NUM_DIGITS-1:0][DIGIT_W-1:0]    digits,
    output unit_status_t                          status
);

    localparam int CNT_W = $clog2(AVG_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(AVG_W - 1);

    logic [AVG_W-1:0]                   shift_reg;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd_reg;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0] adjusted;
    logic [BCD_W-1:0]                   adjusted_flat;
    logic [CNT_W-1:0]                   cnt_reg;
    logic                               busy_reg;
    logic                               done_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i] >= 4'd5)
            begin
                adjusted[i] = bcd_reg[i] + 4'd3;
            end
            else
            begin
                adjusted[i] = bcd_reg[i];
            end
        end
    end

    assign adjusted_flat = adjusted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= value;
            bcd_reg   <= '0;
        end
        else if (busy_reg)
        begin
            bcd_reg   <= {adjusted_flat[BCD_W-2:0], shift_reg[AVG_W-1]};
            shift_reg <= shift_reg << 1;
        end
    end

    assign digits      = bcd_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

>>> rtl/core/smoothed_temperature_seven_segment_scan.sv
// Smoothed temperature reader for a four-digit multiplexed seven-segment display.
// Input stream: s_tdata[9:0] carries the converter reading, s_tuser selects a
// priming sample (0) or one display scan slot (1). Output stream: one result per
// request with segments, one-hot digit enable, a sample flag and the average.
// The APB port holds the reference voltage (0x0) and the frames per sample (0x4).
// Requests are processed one at a time: s_tready is high only while the block is
// idle, and the next request can be taken in the cycle after a result is loaded.
// A scan slot at positions 1 to 3 goes from idle straight to the done state, from
// which the output register is loaded and m_tvalid is raised. A request that takes
// a sample passes through the serial multiplier, the serial divider for the scaling
// (skipped when the result saturates), the ring memory port (read, then update), the
// divider again for the average and the load of the output register. A slot at
// position 0 adds the serial decimal conversion of the latched digits, sampling or not.
// Reset empties the ring at once through per-entry valid flags, so no clearing
// pass is needed, and restores the reset register values.
// A finished result sits in an output register; while the receiver stalls the
// block still accepts and works on the next request, and holds that one until
// the output register is free.
module smoothed_temperature_seven_segment_scan
    import stss_pkg::*;
#(
    parameter int AVG_DEPTH = AVG_DEPTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // APB configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready,
    // Input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // adc_sample[9:0], zero padding above
    input  logic                   s_tuser,   // kind
    // Output stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // segments[7:0], digit_enable[11:8],
                                              // sample_taken[12], average_hundredths[26:13]
);

    // The sum must hold AVG_DEPTH saturated samples.
    localparam int SUM_W = $clog2(AVG_DEPTH * SAMPLE_MAX + 1);
    localparam int IDX_W = $clog2(AVG_DEPTH);
    localparam logic [IDX_W-1:0]     LAST_IDX    = IDX_W'(AVG_DEPTH - 1);
    localparam logic [DIVISOR_W-1:0] DEPTH_DIVISOR = DIVISOR_W'(AVG_DEPTH);

    // Configuration registers.
    logic [CFG_W-1:0] vref_reg;
    logic [CFG_W-1:0] frames_reg;

    // Control and architectural state.
    state_t                             state_reg;
    state_t                             state_next;
    scan_pos_t                          pos_reg;
    logic [CFG_W-1:0]                   frame_reg;
    logic [IDX_W-1:0]                   ring_idx_reg;
    logic [SUM_W-1:0]                   sum_reg;
    logic [AVG_W-1:0]                   avg_reg;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0] latched_reg;
    logic [AVG_DEPTH-1:0]               valid_reg;
    logic                               rd_valid_reg;
    kind_t                              kind_reg;
    logic                               taken_reg;
    logic                               latch_reg;
    logic                               out_valid_reg;

    // Payload registers.
    logic [ADC_W-1:0]       adc_reg;
    logic [PROD_W-1:0]      dividend_reg;
    logic [AVG_W-1:0]       scaled_reg;
    logic [AVG_W-1:0]       rd_data_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    // The ring of recent samples.
    logic [AVG_W-1:0] ring_mem [AVG_DEPTH];

    logic                   cfg_write;
    logic                   accept;
    logic [CFG_W-1:0]       frame_inc;
    logic                   take_hit;
    logic [MCAND_W-1:0]     mcand;
    logic [PROD_W-1:0]      product;
    logic [PROD_W-1:0]      dividend;
    logic                   saturate;
    logic [PROD_W-1:0]      div_dividend;
    logic [DIVISOR_W-1:0]   div_divisor;
    logic [AVG_W-1:0]       quotient;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd_digits;
    logic [AVG_W-1:0]       old_sample;
    logic [SUM_W-1:0]       sum_next;
    logic [SEG_W-1:0]       seg_value;
    logic [EN_W-1:0]        en_value;
    logic [OUT_TDATA_W-1:0] out_data_next;
    unit_status_t           mul_status;
    unit_status_t           div_status;
    unit_status_t           bcd_status;
    logic                   mul_start;
    logic                   div_start;
    logic                   bcd_start;
    logic                   ring_rd;
    logic                   ring_wr;
    logic                   out_load;

    // ------------------------------------------------------------------
    // Configuration port. Registers are decoded on the word address bit.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vref_reg   <= VREF_RESET;
            frames_reg <= FRAMES_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_index_t'(paddr[2]))
                REG_VREF_MV:       vref_reg   <= pwdata[CFG_W-1:0];
                REG_SAMPLE_FRAMES: frames_reg <= pwdata[CFG_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index_t'(paddr[2]))
            REG_VREF_MV:       prdata = APB_DATA_W'(vref_reg);
            REG_SAMPLE_FRAMES: prdata = APB_DATA_W'(frames_reg);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Arithmetic units. The divider is shared between the scaling by the
    // converter full scale and the averaging by the ring depth.
    // ------------------------------------------------------------------
    // The reference times ten is a pair of shifted copies added together.
    assign mcand = MCAND_W'({vref_reg, 3'b000}) + MCAND_W'({vref_reg, 1'b0});

    stss_sermul u_sermul
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mul_start),
        .multiplier   (adc_reg),
        .multiplicand (mcand),
        .product      (product),
        .status       (mul_status)
    );

    assign dividend = product + ROUND_BIAS;
    // Any rounded product at or above this limit gives a quotient above the cap.
    assign saturate = (dividend >= SAT_LIMIT);

    always_comb
    begin
        if (state_reg == ST_AVG_GO)
        begin
            div_dividend = {{(PROD_W - SUM_W){1'b0}}, sum_reg};
            div_divisor  = DEPTH_DIVISOR;
        end
        else
        begin
            div_dividend = dividend_reg;
            div_divisor  = SCALE_DIVISOR;
        end
    end

    stss_serdiv u_serdiv
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (quotient),
        .status   (div_status)
    );

    stss_bcd u_bcd
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (bcd_start),
        .value  (avg_reg),
        .digits (bcd_digits),
        .status (bcd_status)
    );

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    assign frame_inc = frame_reg + 1'b1;
    assign take_hit  = (frame_inc >= frames_reg);
    assign accept    = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (kind_t'(s_tuser) == KIND_PRIME)
                    begin
                        state_next = ST_MUL_GO;
                    end
                    else if (pos_reg == POS_UNITS)
                    begin
                        state_next = take_hit ? ST_MUL_GO : ST_BCD_GO;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_MUL_GO:
            begin
                state_next = ST_MUL_WAIT;
            end
            ST_MUL_WAIT:
            begin
                if (mul_status.done)
                begin
                    state_next = saturate ? ST_RING_RD : ST_DIV_GO;
                end
            end
            ST_DIV_GO:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_status.done)
                begin
                    state_next = ST_RING_RD;
                end
            end
            ST_RING_RD:
            begin
                state_next = ST_RING_UPD;
            end
            ST_RING_UPD:
            begin
                state_next = ST_AVG_GO;
            end
            ST_AVG_GO:
            begin
                state_next = ST_AVG_WAIT;
            end
            ST_AVG_WAIT:
            begin
                if (div_status.done)
                begin
                    state_next = latch_reg ? ST_BCD_GO : ST_DONE;
                end
            end
            ST_BCD_GO:
            begin
                state_next = ST_BCD_WAIT;
            end
            ST_BCD_WAIT:
            begin
                if (bcd_status.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready  = 1'b0;
        mul_start = 1'b0;
        div_start = 1'b0;
        bcd_start = 1'b0;
        ring_rd   = 1'b0;
        ring_wr   = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE:     s_tready  = 1'b1;
            ST_MUL_GO:   mul_start = 1'b1;
            ST_DIV_GO:   div_start = 1'b1;
            ST_AVG_GO:   div_start = 1'b1;
            ST_BCD_GO:   bcd_start = 1'b1;
            ST_RING_RD:  ring_rd   = 1'b1;
            ST_RING_UPD: ring_wr   = 1'b1;
            ST_DONE:     out_load  = !out_valid_reg || m_tready;
            default:     ;
        endcase
    end

    // ------------------------------------------------------------------
    // Ring update. An entry that was never written reads as zero.
    // ------------------------------------------------------------------
    assign old_sample = rd_valid_reg ? rd_data_reg : '0;
    assign sum_next   = sum_reg - SUM_W'(old_sample) + SUM_W'(scaled_reg);

    always_ff @(posedge clk)
    begin
        if (ring_wr)
        begin
            ring_mem[ring_idx_reg] <= scaled_reg;
        end
        if (ring_rd)
        begin
            rd_data_reg <= ring_mem[ring_idx_reg];
        end
    end

    // ------------------------------------------------------------------
    // Result formatting. The hundreds digit carries the decimal point and a
    // zero thousands digit is blanked. Priming requests show nothing.
    // ------------------------------------------------------------------
    always_comb
    begin
        seg_value = seg_pattern(latched_reg[pos_reg]);
        if (pos_reg == POS_HUNDREDS)
        begin
            seg_value = seg_value | DP_MASK;
        end
        else if ((pos_reg == POS_THOUSANDS) && (latched_reg[POS_THOUSANDS] == '0))
        begin
            seg_value = '0;
        end
        en_value = EN_W'(1) << pos_reg;
        if (kind_reg == KIND_PRIME)
        begin
            seg_value = '0;
            en_value  = '0;
        end
        out_data_next = {{(OUT_TDATA_W - SEG_W - EN_W - 1 - AVG_W){1'b0}},
                         avg_reg, taken_reg, en_value, seg_value};
    end

    // ------------------------------------------------------------------
    // State registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= POS_UNITS;
            frame_reg     <= '0;
            ring_idx_reg  <= '0;
            sum_reg       <= '0;
            avg_reg       <= '0;
            latched_reg   <= '0;
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            kind_reg      <= KIND_PRIME;
            taken_reg     <= 1'b0;
            latch_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (accept)
            begin
                kind_reg <= kind_t'(s_tuser);
                if (kind_t'(s_tuser) == KIND_PRIME)
                begin
                    taken_reg <= 1'b1;
                    latch_reg <= 1'b0;
                end
                else if (pos_reg == POS_UNITS)
                begin
                    taken_reg <= take_hit;
                    latch_reg <= 1'b1;
                    frame_reg <= take_hit ? '0 : frame_inc;
                end
                else
                begin
                    taken_reg <= 1'b0;
                    latch_reg <= 1'b0;
                end
            end

            if (ring_rd)
            begin
                rd_valid_reg <= valid_reg[ring_idx_reg];
            end

            if (ring_wr)
            begin
                valid_reg[ring_idx_reg] <= 1'b1;
                sum_reg                 <= sum_next;
                ring_idx_reg            <= (ring_idx_reg == LAST_IDX) ? '0
                                                                      : ring_idx_reg + 1'b1;
            end

            if ((state_reg == ST_AVG_WAIT) && div_status.done)
            begin
                avg_reg <= quotient;
            end

            if ((state_reg == ST_BCD_WAIT) && bcd_status.done)
            begin
                latched_reg <= bcd_digits;
            end

            if (out_load && (kind_reg == KIND_SCAN))
            begin
                pos_reg <= scan_pos_t'(2'(pos_reg + 2'd1));
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            adc_reg <= s_tdata[ADC_W-1:0];
        end
        if ((state_reg == ST_MUL_WAIT) && mul_status.done)
        begin
            dividend_reg <= dividend;
            if (saturate)
            begin
                scaled_reg <= SAT_VALUE;
            end
        end
        if ((state_reg == ST_DIV_WAIT) && div_status.done)
        begin
            scaled_reg <= quotient;
        end
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

>>> rtl/core/stss_checker.sv
`include "assert_macros.svh"

// Port-level checks on the result stream.
module stss_checker
    import stss_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // A stalled result stays offered and unchanged.
    `STSS_ASSERT_NEXT(a_hold_stalled, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // At most one digit is driven at a time.
    `STSS_ASSERT_IMPLY(a_enable_onehot, m_tvalid, $onehot0(m_tdata[11:8]))

    // A result without a digit comes from a priming request: dark, and a sample taken.
    `STSS_ASSERT_IMPLY(a_priming_dark, m_tvalid && (m_tdata[11:8] == 4'b0000),
        (m_tdata[7:0] == 8'h00) && m_tdata[12])

    // The hundreds digit always carries the decimal point.
    `STSS_ASSERT_IMPLY(a_hundreds_point, m_tvalid && (m_tdata[11:8] == 4'b0100), m_tdata[7])

    // The average never exceeds the saturation value.
    `STSS_ASSERT_IMPLY(a_average_range, m_tvalid, m_tdata[26:13] <= SAT_VALUE)

endmodule

bind smoothed_temperature_seven_segment_scan stss_checker u_stss_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> bench/tb_smoothed_temperature_seven_segment_scan.sv
`timescale 1ns / 100ps

// Self-checking bench for the smoothed temperature display scanner.
// Requests go in on the s_ stream, one result per request comes back on the m_ stream,
// and every result is compared field by field against a behavioral copy of the block
// kept in this file. Registers are only touched while the block is idle.
module tb_smoothed_temperature_seven_segment_scan;
    import stss_pkg::*;

    localparam int RING_DEPTH = AVG_DEPTH_DEFAULT;

    // Segment glyphs for 0..9, indexed by digit value.
    localparam logic [9:0][SEG_W-1:0] DIGIT_GLYPH =
    {
        8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
    };

    typedef struct packed
    {
        kind_t               kind;
        logic [ADC_W-1:0]    reading;
    } scan_request_t;

    typedef struct packed
    {
        logic [SEG_W-1:0]    segments;
        logic [EN_W-1:0]     digit_enable;
        logic                sample_taken;
        logic [AVG_W-1:0]    average;
    } display_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;   // adc_sample[9:0], zero padding above
    logic                   s_tuser = 1'b0; // kind
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;        // segments[7:0], digit_enable[11:8],
                                            // sample_taken[12], average_hundredths[26:13]

    smoothed_temperature_seven_segment_scan DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Requests waiting for the driver, and display results the block still owes us.
    scan_request_t request_q[$];
    display_t      display_due[$];

    // Behavioral copy of the block: register settings and display state.
    logic [CFG_W-1:0]   vref_setting   = VREF_RESET;
    logic [CFG_W-1:0]   frames_setting = FRAMES_RESET;
    scan_pos_t          scan_pos       = POS_UNITS;
    logic [15:0]        frame_tally    = '0;
    logic [AVG_W-1:0]   ring_entry [RING_DEPTH];
    int                 ring_slot      = 0;
    int                 ring_sum       = 0;
    logic [AVG_W-1:0]   average_now    = '0;
    logic [DIGIT_W-1:0] shown_digits [NUM_DIGITS];

    initial
    begin
        foreach (ring_entry[i])
            ring_entry[i] = '0;
        foreach (shown_digits[i])
            shown_digits[i] = '0;
    end

    // Handshake bookkeeping shared between the driver, the receiver and the monitor.
    logic        took_request = 1'b0;
    logic        took_result  = 1'b0;
    bit          tx_idle_on   = 1'b0;
    bit          rx_idle_on   = 1'b0;
    bit          rx_hold      = 1'b0;
    int unsigned tx_gap       = 0;
    int unsigned rx_gap       = 0;

    // Run statistics.
    int requests_queued    = 0;
    int requests_taken     = 0;
    int scan_slots         = 0;
    int results_seen       = 0;
    int ring_samples       = 0;
    int input_stall_cycles = 0;
    int settings_applied   = 0;
    int mismatches         = 0;

    task automatic flag_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
        mismatches++;
        if (mismatches <= 40)
            $display("[%0t] %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    endtask

    // Converter reading to hundredths of a degree, rounded and saturated.
    function automatic logic [AVG_W-1:0] scale_to_hundredths(input logic [ADC_W-1:0] reading);
        logic [63:0] product;
        product = 64'(reading) * 64'(vref_setting) * 64'd10;
        product = (product + 64'd511) / 64'd1023;
        if (product > 64'(SAT_VALUE))
            product = 64'(SAT_VALUE);
        return product[AVG_W-1:0];
    endfunction

    // Push one scaled sample into the averaging ring and refresh the average.
    function automatic void absorb_sample(input logic [ADC_W-1:0] reading);
        logic [AVG_W-1:0] hundredths;
        hundredths = scale_to_hundredths(reading);
        ring_sum = ring_sum - int'(ring_entry[ring_slot]) + int'(hundredths);
        ring_entry[ring_slot] = hundredths;
        ring_slot = (ring_slot + 1) % RING_DEPTH;
        average_now = AVG_W'(ring_sum / RING_DEPTH);
        ring_samples++;
    endfunction

    // What the display shows for one request, advancing the scan state as the block does.
    function automatic display_t predict_display(input kind_t kind,
                                                 input logic [ADC_W-1:0] reading);
        display_t           shown;
        logic [DIGIT_W-1:0] digit;
        shown = '0;
        if (kind == KIND_PRIME)
        begin
            absorb_sample(reading);
            shown.sample_taken = 1'b1;
        end
        else
        begin
            if (scan_pos == POS_UNITS)
            begin
                // A new frame starts: maybe sample, then freeze the digits for the frame.
                frame_tally = frame_tally + 16'd1;
                if (frame_tally >= frames_setting)
                begin
                    frame_tally = '0;
                    absorb_sample(reading);
                    shown.sample_taken = 1'b1;
                end
                shown_digits[0] = DIGIT_W'(average_now % 10);
                shown_digits[1] = DIGIT_W'((average_now / 10) % 10);
                shown_digits[2] = DIGIT_W'((average_now / 100) % 10);
                shown_digits[3] = DIGIT_W'((average_now / 1000) % 10);
            end
            digit = shown_digits[scan_pos];
            shown.segments = DIGIT_GLYPH[digit];
            if (scan_pos == POS_HUNDREDS)
                shown.segments = shown.segments | DP_MASK;
            else if (scan_pos == POS_THOUSANDS && digit == '0)
                shown.segments = '0;   // leading zero is blanked
            shown.digit_enable = EN_W'(1) << scan_pos;
            scan_pos = scan_pos_t'(scan_pos + 2'd1);
        end
        shown.average = average_now;
        return shown;
    endfunction

    function automatic int unsigned draw_wait(input bit enabled);
        if (!enabled || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    // Sender: offers queued requests, pausing a drawn number of cycles after each one.
    always @(negedge clk)
    begin : request_driver
        scan_request_t next_req;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!(s_tvalid && !took_request))
        begin
            if (s_tvalid)
                tx_gap = draw_wait(tx_idle_on);
            if (tx_gap > 0)
            begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end
            else if (request_q.size() > 0)
            begin
                next_req = request_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= next_req.kind;
                s_tdata  <= {{(IN_TDATA_W - ADC_W){1'b0}}, next_req.reading};
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: after each accepted result it stalls a drawn number of cycles.
    // rx_hold forces a long stall so the block backs up into its input.
    always @(negedge clk)
    begin : result_receiver
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (took_result)
                rx_gap = draw_wait(rx_idle_on);
            if (rx_hold)
                m_tready <= 1'b0;
            else if (rx_gap > 0)
            begin
                rx_gap--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Monitor: predicts on every accepted request and checks every accepted result.
    always @(posedge clk)
    begin : monitor
        display_t got;
        display_t want;
        took_request <= s_tvalid && s_tready;
        took_result  <= m_tvalid && m_tready;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            got.segments     = m_tdata[7:0];
            got.digit_enable = m_tdata[11:8];
            got.sample_taken = m_tdata[12];
            got.average      = m_tdata[26:13];
            if (display_due.size() == 0)
            begin
                flag_mismatch("result with no request outstanding", m_tdata, 0);
            end
            else
            begin
                want = display_due.pop_front();
                if (got.segments !== want.segments)
                    flag_mismatch($sformatf("result %0d segments", results_seen),
                                  got.segments, want.segments);
                if (got.digit_enable !== want.digit_enable)
                    flag_mismatch($sformatf("result %0d digit_enable", results_seen),
                                  got.digit_enable, want.digit_enable);
                if (got.sample_taken !== want.sample_taken)
                    flag_mismatch($sformatf("result %0d sample_taken", results_seen),
                                  got.sample_taken, want.sample_taken);
                if (got.average !== want.average)
                    flag_mismatch($sformatf("result %0d average_hundredths", results_seen),
                                  got.average, want.average);
                if (m_tdata[OUT_TDATA_W-1:27] !== '0)
                    flag_mismatch($sformatf("result %0d tdata padding", results_seen),
                                  m_tdata[OUT_TDATA_W-1:27], 0);
            end
        end
        if (rst_n && s_tvalid && s_tready)
        begin
            requests_taken++;
            if (s_tuser == KIND_SCAN)
                scan_slots++;
            display_due.push_back(predict_display(kind_t'(s_tuser), s_tdata[ADC_W-1:0]));
        end
        if (rst_n && s_tvalid && !s_tready)
            input_stall_cycles++;
    end

    function automatic void queue_request(input kind_t kind, input logic [ADC_W-1:0] reading);
        scan_request_t req;
        req.kind    = kind;
        req.reading = reading;
        request_q.push_back(req);
        requests_queued++;
    endfunction

    // Readings lean toward the range that does not saturate at the current reference,
    // so the average walks through many digit patterns, with extremes mixed in.
    function automatic logic [ADC_W-1:0] pick_reading();
        int unsigned unsaturated;
        unsaturated = (9999 * 1023) / (int'(vref_setting) * 10);
        if (unsaturated > 1023)
            unsaturated = 1023;
        case ($urandom_range(0, 9))
            0:       return '1;
            1:       return '0;
            2, 3, 4: return ADC_W'($urandom_range(0, 1023));
            default: return ADC_W'($urandom_range(0, unsaturated));
        endcase
    endfunction

    // Mostly scan slots, as on a live display, with priming samples sprinkled in.
    function automatic void queue_random_request();
        queue_request(($urandom_range(0, 4) == 0) ? KIND_PRIME : KIND_SCAN, pick_reading());
    endfunction

    // Returns once every queued request was taken and every result has come back.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (requests_taken != requests_queued || display_due.size() != 0);
    endtask

    task automatic check_register(input reg_index_t which, input logic [CFG_W-1:0] want);
        logic [APB_DATA_W-1:0] got;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {which, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        got = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== APB_DATA_W'(want))
            flag_mismatch({"read of ", which.name()}, got, want);
    endtask

    task automatic write_register(input reg_index_t which, input logic [CFG_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (which == REG_VREF_MV)
            vref_setting = value;
        else
            frames_setting = value;
        check_register(which, value);
    endtask

    task automatic apply_settings(input logic [CFG_W-1:0] vref, input logic [CFG_W-1:0] frames);
        write_register(REG_VREF_MV, vref);
        write_register(REG_SAMPLE_FRAMES, frames);
        settings_applied++;
    endtask

    // One random stretch, split by a full drain so the sender also pauses mid-phase.
    task automatic run_random_phase(input int count, input bit tx_on, input bit rx_on);
        repeat (2)
        begin
            @(posedge clk);
            tx_idle_on = tx_on;
            rx_idle_on = rx_on;
            repeat (count / 2)
                queue_random_request();
            wait_idle();
        end
    endtask

    // The receiver stops for a long stretch while the sender keeps offering back to back.
    // The block finishes one result, takes one more request and then has to refuse input.
    task automatic run_backpressure_burst();
        @(posedge clk);
        tx_idle_on = 1'b0;
        rx_hold    = 1'b1;
        repeat (40)
            queue_random_request();
        repeat (600)
            @(posedge clk);
        rx_hold = 1'b0;
        wait_idle();
    endtask

    initial
    begin : stimulus
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Registers come up at their reset values.
        check_register(REG_VREF_MV, VREF_RESET);
        check_register(REG_SAMPLE_FRAMES, FRAMES_RESET);

        // Directed part, no idling on either side. Reset settings first: an empty ring
        // shows all zeros with the thousands digit blanked, then full-scale primes
        // saturate and pull the average up.
        @(posedge clk);
        repeat (4)
            queue_request(KIND_SCAN, '0);
        queue_request(KIND_PRIME, '1);
        queue_request(KIND_PRIME, '1);
        repeat (4)
            queue_request(KIND_SCAN, 10'h155);
        wait_idle();

        // Zero frames per sample means every frame samples; the largest reference
        // saturates nearly any reading.
        apply_settings(16'hFFFF, 16'd0);
        @(posedge clk);
        repeat (4)
            queue_request(KIND_SCAN, 10'h2AA);
        queue_request(KIND_PRIME, 10'h155);
        wait_idle();

        // Lowest reference: full scale lands one count above the saturation point,
        // one count below it does not saturate.
        apply_settings(16'd1000, 16'd1);
        @(posedge clk);
        repeat (4)
            queue_request(KIND_SCAN, '1);
        queue_request(KIND_PRIME, 10'd1022);
        repeat (4)
            queue_request(KIND_SCAN, '0);
        wait_idle();

        // Random part across several settings, extremes included.
        apply_settings(16'd1000, 16'd1);
        run_random_phase(150, 1'b1, 1'b1);

        apply_settings(16'hFFFF, 16'hFFFF);
        run_random_phase(150, 1'b1, 1'b0);

        apply_settings(CFG_W'($urandom_range(1000, 65535)), CFG_W'($urandom_range(1, 4)));
        run_backpressure_burst();
        run_random_phase(150, 1'b1, 1'b1);

        apply_settings(16'd3300, 16'd2);
        run_random_phase(150, 1'b0, 1'b1);

        apply_settings(CFG_W'($urandom_range(1000, 65535)), CFG_W'($urandom_range(1, 65535)));
        run_random_phase(150, 1'b1, 1'b1);

        apply_settings(VREF_RESET, FRAMES_RESET);
        run_random_phase(150, 1'b1, 1'b1);

        // Give a stray extra result time to show up before closing.
        repeat (100)
            @(posedge clk);

        $display("Covered %0d requests (%0d scan slots), %0d results, %0d ring samples.",
                 requests_taken, scan_slots, results_seen, ring_samples);
        $display("Used %0d register settings; input was held off for %0d cycles.",
                 settings_applied, input_stall_cycles);
        if (mismatches == 0)
            $display("smoothed_temperature_seven_segment_scan: match");
        else
            $display("smoothed_temperature_seven_segment_scan: mismatch");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin
        #20_000_000;
        $display("Timed out with %0d results still owed.", display_due.size());
        $display("smoothed_temperature_seven_segment_scan: mismatch");
        $finish;
    end

endmodule
